// ===== src/clut_pkg.sv =====
`timescale 1ns / 1ps

package clut_pkg;

    // pixel mode register codes
    localparam logic [1:0] MODE_IDX4  = 2'd0;
    localparam logic [1:0] MODE_IDX8  = 2'd1;
    localparam logic [1:0] MODE_RGB16 = 2'd2;
    localparam logic [1:0] MODE_RGB24 = 2'd3;

    // request command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // 24-bit triplet phase codes
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // where a pixel's color comes from
    typedef enum logic [1:0] {
        SRC_PALETTE,
        SRC_DIRECT,
        SRC_RAW
    } pix_src_t;

    // one pixel on its way from the sequencer to the output stage
    typedef struct packed {
        pix_src_t    src;
        logic [15:0] color;
        logic [7:0]  raw_r;
        logic [7:0]  raw_g;
        logic [7:0]  raw_b;
        logic        oob;
        logic        run_last;
        logic        image_done;
    } pix_meta_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    // 5-bit fields shifted up by three, alpha opaque unless all bits clear
    function automatic rgba_t expand_color(input logic [15:0] c);
        rgba_t px;
        px.r = {c[4:0], 3'b000};
        px.g = {c[9:5], 3'b000};
        px.b = {c[14:10], 3'b000};
        px.a = (c != 16'h0000) ? ALPHA_OPAQUE : ALPHA_CLEAR;
        return px;
    endfunction

endpackage

// ===== src/clut_palette_ram.sv =====
`timescale 1ns / 1ps

module clut_palette_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while no new read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/clut_word_seq.sv =====
`timescale 1ns / 1ps

module clut_word_seq #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             pixel_mode,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [7:0]             palette_slot,
    input  logic [15:0]            palette_color,
    input  logic [15:0]            data_word,
    input  logic                   image_end,
    output logic                   ram_wr_en,
    output logic [AW-1:0]          ram_wr_addr,
    output logic [15:0]            ram_wr_data,
    output logic                   ram_rd_en,
    output logic [AW-1:0]          ram_rd_addr,
    output logic                   iss_valid,
    input  logic                   iss_ready,
    output clut_pkg::pix_meta_t    iss_meta
);

    localparam logic [8:0] DEPTH_W = 9'(DEPTH);

    // held request
    logic        item_valid_reg, item_valid_next;
    logic        item_cmd_reg;
    logic [7:0]  item_slot_reg;
    logic [15:0] item_color_reg;
    logic [15:0] item_word_reg;
    logic        item_end_reg;

    // pixel counter within a word, 24-bit triplet state
    logic [1:0]  pix_cnt_reg, pix_cnt_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] held_reg, held_next;

    logic [1:0]  last_cnt;
    logic        produces;
    logic        last_pix;
    logic [7:0]  idx8;
    logic        iss_fire;
    logic        item_done;
    logic        in_fire;
    logic        is_decode;

    assign is_decode = (item_cmd_reg == clut_pkg::CMD_DECODE);

    // pixels per word for the current mode
    always_comb
    begin
        produces = 1'b1;
        last_cnt = 2'd0;
        case (pixel_mode)
            clut_pkg::MODE_IDX4:  last_cnt = 2'd3;
            clut_pkg::MODE_IDX8:  last_cnt = 2'd1;
            clut_pkg::MODE_RGB16: last_cnt = 2'd0;
            clut_pkg::MODE_RGB24:
            begin
                last_cnt = 2'd1;
                produces = (phase_reg == clut_pkg::PHASE_THIRD);
            end
            default: last_cnt = 2'd0;
        endcase
    end

    assign last_pix = (pix_cnt_reg == last_cnt);

    // palette index of the current pixel
    always_comb
    begin
        if (pixel_mode == clut_pkg::MODE_IDX4)
        begin
            case (pix_cnt_reg)
                2'd0:    idx8 = {4'h0, item_word_reg[3:0]};
                2'd1:    idx8 = {4'h0, item_word_reg[7:4]};
                2'd2:    idx8 = {4'h0, item_word_reg[11:8]};
                default: idx8 = {4'h0, item_word_reg[15:12]};
            endcase
        end
        else
        begin
            idx8 = pix_cnt_reg[0] ? item_word_reg[15:8] : item_word_reg[7:0];
        end
    end

    // pixel description handed downstream
    always_comb
    begin
        iss_meta            = '0;
        iss_meta.color      = item_word_reg;
        iss_meta.run_last   = last_pix;
        iss_meta.image_done = last_pix & item_end_reg;
        iss_meta.oob        = ({1'b0, idx8} >= DEPTH_W);
        if (pix_cnt_reg[0])
        begin
            iss_meta.raw_r = held_reg[31:24];
            iss_meta.raw_g = item_word_reg[7:0];
            iss_meta.raw_b = item_word_reg[15:8];
        end
        else
        begin
            iss_meta.raw_r = held_reg[7:0];
            iss_meta.raw_g = held_reg[15:8];
            iss_meta.raw_b = held_reg[23:16];
        end
        case (pixel_mode)
            clut_pkg::MODE_IDX4:  iss_meta.src = clut_pkg::SRC_PALETTE;
            clut_pkg::MODE_IDX8:  iss_meta.src = clut_pkg::SRC_PALETTE;
            clut_pkg::MODE_RGB16: iss_meta.src = clut_pkg::SRC_DIRECT;
            default:              iss_meta.src = clut_pkg::SRC_RAW;
        endcase
    end

    // issue and request handshake
    assign iss_valid = item_valid_reg & is_decode & produces;
    assign iss_fire  = iss_valid & iss_ready;
    assign item_done = item_valid_reg &
                       (!is_decode || !produces || (iss_fire && last_pix));
    assign in_stall  = item_valid_reg & !item_done;
    assign in_fire   = in_valid & !in_stall;

    // palette port
    assign ram_wr_en   = item_valid_reg & !is_decode &
                         ({1'b0, item_slot_reg} < DEPTH_W);
    assign ram_wr_addr = item_slot_reg[AW-1:0];
    assign ram_wr_data = item_color_reg;
    assign ram_rd_en   = iss_fire & (iss_meta.src == clut_pkg::SRC_PALETTE);
    assign ram_rd_addr = idx8[AW-1:0];

    // next state
    always_comb
    begin
        item_valid_next = in_fire ? 1'b1 : (item_valid_reg & !item_done);
        pix_cnt_next    = pix_cnt_reg;
        phase_next      = phase_reg;
        held_next       = held_reg;
        if (iss_fire)
        begin
            pix_cnt_next = last_pix ? 2'd0 : pix_cnt_reg + 2'd1;
        end
        if (item_done && is_decode)
        begin
            if (pixel_mode == clut_pkg::MODE_RGB24)
            begin
                case (phase_reg)
                    clut_pkg::PHASE_SECOND:
                    begin
                        held_next  = {item_word_reg, held_reg[15:0]};
                        phase_next = clut_pkg::PHASE_THIRD;
                    end
                    clut_pkg::PHASE_THIRD:
                    begin
                        held_next  = '0;
                        phase_next = clut_pkg::PHASE_FIRST;
                    end
                    default:
                    begin
                        held_next  = {16'h0000, item_word_reg};
                        phase_next = clut_pkg::PHASE_SECOND;
                    end
                endcase
            end
            if (item_end_reg)
            begin
                held_next  = '0;
                phase_next = clut_pkg::PHASE_FIRST;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            pix_cnt_reg    <= 2'd0;
            phase_reg      <= clut_pkg::PHASE_FIRST;
            held_reg       <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            pix_cnt_reg    <= pix_cnt_next;
            phase_reg      <= phase_next;
            held_reg       <= held_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_cmd_reg   <= cmd;
            item_slot_reg  <= palette_slot;
            item_color_reg <= palette_color;
            item_word_reg  <= data_word;
            item_end_reg   <= image_end;
        end
    end

`ifndef SYNTHESIS
    // one palette access per cycle, write and read never overlap
    a_no_wr_rd_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("palette write and read in the same cycle");

    // raw pixels only come out of a completed triplet
    a_raw_needs_triplet: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_valid && pixel_mode == clut_pkg::MODE_RGB24) |->
        (phase_reg == clut_pkg::PHASE_THIRD))
        else $error("24-bit pixel issued outside third phase");

    // pixel counter stays within the word
    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        iss_valid |-> (pix_cnt_reg <= last_cnt))
        else $error("pixel counter beyond last pixel of word");

    // a finished pixel counter wraps back to zero
    a_cnt_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_fire && last_pix) |=> (pix_cnt_reg == 2'd0))
        else $error("pixel counter did not wrap");
`endif

endmodule

// ===== src/clut_pixel_out.sv =====
`timescale 1ns / 1ps

module clut_pixel_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                iss_valid,
    output logic                iss_ready,
    input  clut_pkg::pix_meta_t iss_meta,
    input  logic [15:0]         ram_q,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic [7:0]          alpha,
    output logic                run_last,
    output logic                image_done
);

    // lookup stage, lines up with the palette read data
    logic                b_valid_reg, b_valid_next;
    clut_pkg::pix_meta_t b_meta_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    clut_pkg::rgba_t     px_reg, px_next;
    logic                run_last_reg;
    logic                image_done_reg;

    logic                out_free;
    logic                b_move;
    logic [15:0]         color;

    assign out_free  = !out_valid_reg || !out_stall;
    assign b_move    = b_valid_reg & out_free;
    assign iss_ready = !b_valid_reg || out_free;

    // color selection and expansion
    always_comb
    begin
        if (b_meta_reg.src == clut_pkg::SRC_PALETTE)
        begin
            color = b_meta_reg.oob ? 16'h0000 : ram_q;
        end
        else
        begin
            color = b_meta_reg.color;
        end
        px_next = clut_pkg::expand_color(color);
        if (b_meta_reg.src == clut_pkg::SRC_RAW)
        begin
            px_next.r = b_meta_reg.raw_r;
            px_next.g = b_meta_reg.raw_g;
            px_next.b = b_meta_reg.raw_b;
            px_next.a = clut_pkg::ALPHA_OPAQUE;
        end
    end

    assign b_valid_next   = (iss_valid && iss_ready) ? 1'b1 : (b_valid_reg & !b_move);
    assign out_valid_next = b_move ? 1'b1 : (out_valid_reg & out_stall);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (iss_valid && iss_ready)
        begin
            b_meta_reg <= iss_meta;
        end
        if (b_move)
        begin
            px_reg         <= px_next;
            run_last_reg   <= b_meta_reg.run_last;
            image_done_reg <= b_meta_reg.image_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = px_reg.r;
    assign green      = px_reg.g;
    assign blue       = px_reg.b;
    assign alpha      = px_reg.a;
    assign run_last   = run_last_reg;
    assign image_done = image_done_reg;

endmodule

// ===== src/clut_texel_to_rgba_expander_unit.sv =====
`timescale 1ns / 1ps
// path: request register, lookup stage, output register
// throughput: one pixel per cycle while out_stall is low, set by the single
//   palette read port; a word gives 4 pixels in 4-bit mode, 2 in 8-bit, 1 in
//   16-bit, 2 per three words in 24-bit; a palette write request gives no pixel
// reset: asynchronous active low; clears valids, 24-bit phase and held bytes,
//   mode to 4-bit; palette contents are undefined until written

module clut_texel_to_rgba_expander_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  palette_slot,
    input  logic [15:0] palette_color,
    input  logic [15:0] data_word,
    input  logic        image_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        run_last,
    output logic        image_done
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [1:0]          pixel_mode_reg;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [15:0]         ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [15:0]         ram_q;
    logic                iss_valid;
    logic                iss_ready;
    clut_pkg::pix_meta_t iss_meta;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg <= clut_pkg::MODE_IDX4;
        end
        else if (cfg_write)
        begin
            pixel_mode_reg <= cfg_data;
        end
    end

    // word sequencer
    clut_word_seq #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_mode    (pixel_mode_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .palette_slot  (palette_slot),
        .palette_color (palette_color),
        .data_word     (data_word),
        .image_end     (image_end),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .iss_valid     (iss_valid),
        .iss_ready     (iss_ready),
        .iss_meta      (iss_meta)
    );

    // palette memory
    clut_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    // color expansion and output register
    clut_pixel_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .iss_valid  (iss_valid),
        .iss_ready  (iss_ready),
        .iss_meta   (iss_meta),
        .ram_q      (ram_q),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .run_last   (run_last),
        .image_done (image_done)
    );

endmodule
